// ----- design/ede_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_pkg
// shared types and constants for the edit distance engine
// ----------------------------------------------------------------------------
package ede_pkg;

  // request codes on the input channel
  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_WORD  = 1'b1;

  // reported distance saturates here
  localparam logic [6:0] DIST_MAX = 7'd127;

  // control part of a token travelling down the cell chain
  typedef struct packed {
    logic       valid;  // token present
    logic       upd;    // advance the row (0 = read out only)
    logic       first;  // first character of a word, row is at word start
    logic       last;   // final token of the word, yields a result
    logic       wovf;   // word went past the word limit
    logic       qovf;   // query went past the query limit
    logic [7:0] ch;     // word character
  } ede_tok_t;

endpackage

// ----- design/ede_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_in_if / ede_out_if
// valid/ready channels for request beats and result beats
// ----------------------------------------------------------------------------
interface ede_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_value;
  logic       last;

  modport source (output valid, req_type, char_value, last, input ready);
  modport sink   (input valid, req_type, char_value, last, output ready);
endinterface

interface ede_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] distance;
  logic       word_too_long;
  logic       query_truncated;

  modport source (output valid, distance, word_too_long, query_truncated, input ready);
  modport sink   (input valid, distance, word_too_long, query_truncated, output ready);
endinterface

// ----- design/edit_distance_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine_core
// levenshtein distance of streamed words against a stored query string
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one character per beat: req_type 0 appends a query
//   character (last closes the query), req_type 1 feeds a word character
//   (last closes the word). out_ch returns one beat per finished word with
//   the distance (saturated at 127) and the two overflow flags.
//   the row of the table lives in a chain of MAX_QUERY cells. each word
//   character enters the head and moves one cell per cycle as a wavefront
//   while the chain advances, so one beat per cycle is sustained for both
//   query and word beats unless out_ch stalls. results pass through the
//   head register, one register per cell, then the output register.
//   reset empties the chain and the output register, clears the query
//   (length zero, flags clear) and starts a fresh word. query characters
//   themselves hold no reset value until written.
//   when out_ch stalls with a result pending, the whole chain freezes and
//   in_ch.ready drops; nothing is lost and beats resume where they stopped.
// ----------------------------------------------------------------------------
module edit_distance_engine_core #(
  parameter int MAX_QUERY = 32,
  parameter int MAX_WORD  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ede_in_if.sink    in_ch,
  ede_out_if.source out_ch
);

  // largest row value plus headroom for the +1 terms
  localparam int MAXV = (MAX_QUERY > MAX_WORD) ? MAX_QUERY : MAX_WORD;
  localparam int DW   = $clog2(MAXV + 2);
  localparam int LW   = $clog2(MAX_QUERY + 1);

  // chain advances whenever the output register can take a beat
  logic adv;
  logic acc;

  // query character write broadcast to the cells
  logic          qwr_en;
  logic [LW-1:0] qwr_idx;
  logic [7:0]    qwr_ch;

  // tokens between chain stages, index 0 is the head output
  ede_pkg::ede_tok_t ctl_w  [MAX_QUERY+1];
  logic [LW-1:0]     q_w    [MAX_QUERY+1];
  logic [DW-1:0]     left_w [MAX_QUERY+1];
  logic [DW-1:0]     diag_w [MAX_QUERY+1];

  ede_pkg::ede_tok_t tail_ctl;
  logic [DW-1:0]     tail_left;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] dist_r, dist_nxt;
  logic       wtl_r, wtl_nxt;
  logic       qtr_r, qtr_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  ede_head #(
    .MAX_QUERY (MAX_QUERY),
    .MAX_WORD  (MAX_WORD),
    .DW        (DW),
    .LW        (LW)
  ) u_head (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .acc        (acc),
    .req_type   (in_ch.req_type),
    .char_value (in_ch.char_value),
    .last       (in_ch.last),
    .qwr_en     (qwr_en),
    .qwr_idx    (qwr_idx),
    .qwr_ch     (qwr_ch),
    .tok_ctl    (ctl_w[0]),
    .tok_q      (q_w[0]),
    .tok_left   (left_w[0]),
    .tok_diag   (diag_w[0])
  );

  // one cell per query position
  for (genvar g = 1; g <= MAX_QUERY; g++) begin : g_cell
    ede_cell #(
      .POS (g),
      .DW  (DW),
      .LW  (LW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .qwr_en   (qwr_en),
      .qwr_idx  (qwr_idx),
      .qwr_ch   (qwr_ch),
      .in_ctl   (ctl_w[g-1]),
      .in_q     (q_w[g-1]),
      .in_left  (left_w[g-1]),
      .in_diag  (diag_w[g-1]),
      .out_ctl  (ctl_w[g]),
      .out_q    (q_w[g]),
      .out_left (left_w[g]),
      .out_diag (diag_w[g])
    );
  end

  // past the last active cell the row entry is passed along untouched,
  // so the chain end carries the entry at the query length
  assign tail_ctl  = ctl_w[MAX_QUERY];
  assign tail_left = left_w[MAX_QUERY];

  always_comb begin
    out_valid_nxt = out_valid_r;
    dist_nxt      = dist_r;
    wtl_nxt       = wtl_r;
    qtr_nxt       = qtr_r;
    if (adv) begin
      out_valid_nxt = tail_ctl.valid && tail_ctl.last;
      if (32'(tail_left) > 32'(ede_pkg::DIST_MAX)) begin
        dist_nxt = ede_pkg::DIST_MAX;
      end else begin
        dist_nxt = 7'(tail_left);
      end
      wtl_nxt = tail_ctl.wovf;
      qtr_nxt = tail_ctl.qovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    wtl_r  <= wtl_nxt;
    qtr_r  <= qtr_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.distance        = dist_r;
  assign out_ch.word_too_long   = wtl_r;
  assign out_ch.query_truncated = qtr_r;

  // a stalled output freezes the chain end
  a_stall_freezes_chain: assert property (
    @(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tail_ctl) && $stable(tail_left)
  ) else $error("chain moved while output stalled");

  // a result only appears from a word-ending token at the chain end
  a_result_from_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tail_ctl.valid && tail_ctl.last)
  ) else $error("result without a closing token");

  // query beats never inject a token into the chain
  a_query_no_token: assert property (
    @(posedge clk) disable iff (!rst_n)
    acc && (in_ch.req_type == ede_pkg::REQ_QUERY) |=> !ctl_w[0].valid
  ) else $error("query beat injected a token");

endmodule

// ----- design/ede_head.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_head
// query bookkeeping, word counting and token injection into the cell chain
// ----------------------------------------------------------------------------
module ede_head #(
  parameter int MAX_QUERY = 32,
  parameter int MAX_WORD  = 64,
  parameter int DW        = 7,
  parameter int LW        = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                acc,
  input  logic                req_type,
  input  logic [7:0]          char_value,
  input  logic                last,
  output logic                qwr_en,
  output logic [LW-1:0]       qwr_idx,
  output logic [7:0]          qwr_ch,
  output ede_pkg::ede_tok_t   tok_ctl,
  output logic [LW-1:0]       tok_q,
  output logic [DW-1:0]       tok_left,
  output logic [DW-1:0]       tok_diag
);

  localparam int WCW = $clog2(MAX_WORD + 1);

  logic [LW-1:0]     qlen_r, qlen_nxt;
  logic              qovf_r, qovf_nxt;
  logic              qdone_r, qdone_nxt;
  logic [WCW-1:0]    wc_r, wc_nxt;
  logic              wovf_r, wovf_nxt;
  logic              first_r, first_nxt;

  ede_pkg::ede_tok_t ctl_r, ctl_nxt;
  logic [LW-1:0]     q_r, q_nxt;
  logic [DW-1:0]     left_r, left_nxt;
  logic [DW-1:0]     diag_r, diag_nxt;

  logic [LW-1:0]     qlen_eff;
  logic              qovf_eff;
  logic              word_room;

  always_comb begin
    qlen_nxt  = qlen_r;
    qovf_nxt  = qovf_r;
    qdone_nxt = qdone_r;
    wc_nxt    = wc_r;
    wovf_nxt  = wovf_r;
    first_nxt = first_r;
    ctl_nxt   = ctl_r;
    q_nxt     = q_r;
    left_nxt  = left_r;
    diag_nxt  = diag_r;
    qwr_en    = 1'b0;
    qwr_ch    = char_value;

    // a query beat after a finished query starts over
    qlen_eff  = qdone_r ? '0 : qlen_r;
    qovf_eff  = qdone_r ? 1'b0 : qovf_r;
    qwr_idx   = qlen_eff;
    word_room = 32'(wc_r) < MAX_WORD;

    if (en) begin
      ctl_nxt.valid = 1'b0;
    end

    if (acc) begin
      if (req_type == ede_pkg::REQ_QUERY) begin
        qdone_nxt = last;
        qovf_nxt  = qovf_eff;
        qlen_nxt  = qlen_eff;
        if (32'(qlen_eff) < MAX_QUERY) begin
          qwr_en   = 1'b1;
          qlen_nxt = qlen_eff + LW'(1);
        end else begin
          qovf_nxt = 1'b1;
        end
        // abandon any word in progress
        wc_nxt    = '0;
        wovf_nxt  = 1'b0;
        first_nxt = 1'b1;
      end else begin
        ctl_nxt.upd   = word_room;
        ctl_nxt.first = first_r;
        ctl_nxt.last  = last;
        ctl_nxt.wovf  = wovf_r | ~word_room;
        ctl_nxt.qovf  = qovf_r;
        ctl_nxt.ch    = char_value;
        q_nxt         = qlen_r;
        if (word_room) begin
          ctl_nxt.valid = 1'b1;
          left_nxt      = DW'(wc_r) + DW'(1);
          diag_nxt      = DW'(wc_r);
          wc_nxt        = wc_r + WCW'(1);
          first_nxt     = 1'b0;
        end else begin
          // overflow beat only reads the row out when it ends the word
          ctl_nxt.valid = last;
          left_nxt      = DW'(wc_r);
          diag_nxt      = DW'(wc_r);
          wovf_nxt      = 1'b1;
        end
        if (last) begin
          wc_nxt    = '0;
          wovf_nxt  = 1'b0;
          first_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r    <= '0;
      qovf_r    <= 1'b0;
      qdone_r   <= 1'b1;
      wc_r      <= '0;
      wovf_r    <= 1'b0;
      first_r   <= 1'b1;
      ctl_r     <= '0;
    end else begin
      qlen_r    <= qlen_nxt;
      qovf_r    <= qovf_nxt;
      qdone_r   <= qdone_nxt;
      wc_r      <= wc_nxt;
      wovf_r    <= wovf_nxt;
      first_r   <= first_nxt;
      ctl_r     <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    left_r <= left_nxt;
    diag_r <= diag_nxt;
  end

  assign tok_ctl  = ctl_r;
  assign tok_q    = q_r;
  assign tok_left = left_r;
  assign tok_diag = diag_r;

endmodule

// ----- design/ede_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_cell
// one query position: holds its query character and row entry
// ----------------------------------------------------------------------------
module ede_cell #(
  parameter int POS = 1,
  parameter int DW  = 7,
  parameter int LW  = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                qwr_en,
  input  logic [LW-1:0]       qwr_idx,
  input  logic [7:0]          qwr_ch,
  input  ede_pkg::ede_tok_t   in_ctl,
  input  logic [LW-1:0]       in_q,
  input  logic [DW-1:0]       in_left,
  input  logic [DW-1:0]       in_diag,
  output ede_pkg::ede_tok_t   out_ctl,
  output logic [LW-1:0]       out_q,
  output logic [DW-1:0]       out_left,
  output logic [DW-1:0]       out_diag
);

  logic [7:0]        qc_r;
  logic [DW-1:0]     d_r, d_nxt;
  ede_pkg::ede_tok_t ctl_r;
  logic [LW-1:0]     q_r;
  logic [DW-1:0]     left_r, left_nxt;
  logic [DW-1:0]     diag_r, diag_nxt;

  logic              active;
  logic [DW-1:0]     above, del_c, ins_c, sub_c, best;

  always_comb begin
    active = in_q >= LW'(POS);
    above  = in_ctl.first ? DW'(POS) : d_r;
    del_c  = above + DW'(1);
    ins_c  = in_left + DW'(1);
    sub_c  = in_diag + ((qc_r == in_ctl.ch) ? DW'(0) : DW'(1));
    best   = (del_c < ins_c) ? del_c : ins_c;
    best   = (best < sub_c) ? best : sub_c;

    d_nxt    = d_r;
    left_nxt = in_left;
    diag_nxt = above;
    if (in_ctl.valid && active) begin
      if (in_ctl.upd) begin
        d_nxt    = best;
        left_nxt = best;
      end else begin
        left_nxt = d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qwr_en && (qwr_idx == LW'(POS - 1))) begin
      qc_r <= qwr_ch;
    end
    if (en) begin
      d_r    <= d_nxt;
      q_r    <= in_q;
      left_r <= left_nxt;
      diag_r <= diag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_q    = q_r;
  assign out_left = left_r;
  assign out_diag = diag_r;

endmodule

// ----- tb/edit_distance_engine_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine_core_tb
// self-checking bench for the levenshtein edit distance engine
// ----------------------------------------------------------------------------
// a scoreboard model keeps its own query store and distance row, scores every
// accepted word beat and queues the expected result beat. a checker process
// compares each result beat field by field with the oldest expectation.
// directed tests cover empty query, exact and near matches, a partial query,
// a word cut by a query beat, query overflow and word overflow. random
// traffic then sends well-formed queries and words with a mix of noise,
// while both channel sides idle at random.
// ----------------------------------------------------------------------------
module edit_distance_engine_core_tb;

  localparam int QLEN_MAX = 32;  // query store depth
  localparam int WLEN_MAX = 64;  // longest word that is compared
  localparam int PIPE_LAT = QLEN_MAX + 2;  // last word beat to result beat

  typedef struct packed {
    logic [6:0] distance;
    logic       word_too_long;
    logic       query_truncated;
  } score_t;

  logic clk = 1'b0;
  logic rst_n;

  ede_in_if  req_bus ();
  ede_out_if score_bus ();

  edit_distance_engine_core #(
    .MAX_QUERY(QLEN_MAX),
    .MAX_WORD (WLEN_MAX)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_bus),
    .out_ch(score_bus)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // scoreboard model state
  // --------------------------------------------------------------------------
  logic [7:0] qry_chars [QLEN_MAX];
  logic [5:0] qry_len;
  logic       qry_ovf;
  logic       qry_closed;
  logic [6:0] dist_row [QLEN_MAX + 1];
  logic [6:0] word_len;
  logic       word_ovf;

  score_t pending_scores [$];

  // run bookkeeping
  int beats_sent;
  int words_scored;
  int wovf_seen;
  int qovf_seen;
  int error_count;
  int req_idle_pct;    // chance in percent that the sender idles before a beat
  int score_idle_pct;  // chance in percent that the receiver stalls a beat
  logic [7:0] sym_base;  // small alphabet base so that matches are common

  // fresh word: row of an empty word
  function automatic void word_restart();
    for (int j = 0; j <= QLEN_MAX; j++) dist_row[j] = 7'(j);
    word_len = '0;
    word_ovf = 1'b0;
  endfunction

  // one row step of the levenshtein table for word character ch
  function automatic void row_advance(logic [7:0] ch);
    logic [7:0] diag;
    logic [7:0] above;
    logic [7:0] best;
    logic [7:0] alt;
    diag        = {1'b0, dist_row[0]};
    dist_row[0] = word_len + 7'd1;
    for (int j = 1; j <= qry_len; j++) begin
      above = {1'b0, dist_row[j]};
      best  = above + 8'd1;                             // deletion
      alt   = {1'b0, dist_row[j-1]} + 8'd1;             // insertion
      if (alt < best) best = alt;
      alt   = diag + ((qry_chars[j-1] == ch) ? 8'd0 : 8'd1);  // substitution
      if (alt < best) best = alt;
      dist_row[j] = best[6:0];
      diag        = above;
    end
  endfunction

  // model update for one accepted request beat
  function automatic void score_beat(logic rt, logic [7:0] ch, logic lst);
    score_t exp_s;
    logic [7:0] d;
    if (rt == ede_pkg::REQ_QUERY) begin
      if (qry_closed) begin
        qry_len    = '0;
        qry_ovf    = 1'b0;
        qry_closed = 1'b0;
      end
      if (qry_len < QLEN_MAX) begin
        qry_chars[qry_len[4:0]] = ch;
        qry_len                 = qry_len + 6'd1;
      end else begin
        qry_ovf = 1'b1;
      end
      if (lst) qry_closed = 1'b1;
      // any query beat drops the word in progress
      word_restart();
    end else begin
      if (word_len < WLEN_MAX) begin
        row_advance(ch);
        word_len = word_len + 7'd1;
      end else begin
        word_ovf = 1'b1;
      end
      if (lst) begin
        d = {1'b0, dist_row[qry_len]};
        exp_s.distance        = (d > ede_pkg::DIST_MAX) ? ede_pkg::DIST_MAX : d[6:0];
        exp_s.word_too_long   = word_ovf;
        exp_s.query_truncated = qry_ovf;
        pending_scores = {pending_scores, exp_s};
        word_restart();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int draw_wait(int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(1, 19);
    return 0;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 15;
      2:       return 50;
      default: return 90;
    endcase
  endfunction

  // mostly a four-symbol alphabet, sometimes any byte
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return sym_base + 8'($urandom_range(0, 3));
  endfunction

  // one request beat: optional idle gap, then hold valid until accepted.
  // valid stays high after the beat so back-to-back beats need no toggle
  task automatic send_beat(logic rt, logic [7:0] ch, logic lst);
    int gap;
    gap = draw_wait(req_idle_pct);
    @(negedge clk);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= rt;
    req_bus.char_value <= ch;
    req_bus.last       <= lst;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    score_beat(rt, ch, lst);
    beats_sent++;
  endtask

  task automatic send_query(int len, logic close);
    for (int i = 0; i < len; i++)
      send_beat(ede_pkg::REQ_QUERY, pick_char(), close && (i == len - 1));
  endtask

  task automatic send_word(int len, logic close);
    for (int i = 0; i < len; i++)
      send_beat(ede_pkg::REQ_WORD, pick_char(), close && (i == len - 1));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // nothing loaded since reset: distance is the word length
  task automatic test_no_query();
    send_beat(ede_pkg::REQ_WORD, 8'h00, 1'b1);
    send_beat(ede_pkg::REQ_WORD, 8'hFF, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'h80, 1'b1);
  endtask

  // byte extremes in the query, exact match and one-edit words
  task automatic test_basic_match();
    send_beat(ede_pkg::REQ_QUERY, 8'h00, 1'b0);
    send_beat(ede_pkg::REQ_QUERY, 8'hFF, 1'b0);
    send_beat(ede_pkg::REQ_QUERY, 8'h55, 1'b1);
    send_beat(ede_pkg::REQ_WORD, 8'h00, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'hFF, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'h55, 1'b1);
    send_beat(ede_pkg::REQ_WORD, 8'hFF, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'h55, 1'b1);
    send_beat(ede_pkg::REQ_WORD, 8'h00, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'hAA, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'h55, 1'b1);
  endtask

  // words against an open query, then a query beat that kills a word
  task automatic test_partial_query();
    send_beat(ede_pkg::REQ_QUERY, 8'hAA, 1'b0);
    send_beat(ede_pkg::REQ_WORD, 8'hAA, 1'b1);
    send_beat(ede_pkg::REQ_QUERY, 8'hBB, 1'b1);  // appends, query is now two chars
    send_beat(ede_pkg::REQ_WORD, 8'hBB, 1'b1);
    send_beat(ede_pkg::REQ_WORD, 8'h01, 1'b0);
    send_beat(ede_pkg::REQ_QUERY, 8'h02, 1'b1);  // starts a new query, word dropped
    send_beat(ede_pkg::REQ_WORD, 8'h02, 1'b1);
    send_beat(ede_pkg::REQ_WORD, 8'h7F, 1'b1);
  endtask

  // query past the store depth, exactly full, and an open overlong query
  task automatic test_query_overflow();
    sym_base = 8'h41;
    send_query(QLEN_MAX + 8, 1'b1);
    send_word(10, 1'b1);
    send_word(QLEN_MAX + 4, 1'b1);
    send_query(QLEN_MAX, 1'b1);
    send_word(QLEN_MAX, 1'b1);
    send_query(QLEN_MAX + 2, 1'b0);
    send_word(5, 1'b1);
    send_beat(ede_pkg::REQ_QUERY, pick_char(), 1'b1);
    send_word(3, 1'b1);
    send_query(3, 1'b1);  // flag clears with the next query
    send_word(3, 1'b1);
  endtask

  // words at, just past and well past the word limit
  task automatic test_word_overflow();
    sym_base = 8'hF0;
    send_query(6, 1'b1);
    send_word(WLEN_MAX, 1'b1);
    send_word(WLEN_MAX + 1, 1'b1);
    send_word(WLEN_MAX + 6, 1'b1);
    send_query(QLEN_MAX, 1'b1);
    send_word(WLEN_MAX + 2, 1'b1);
  endtask

  // mostly well-formed queries and words, some cut words and open queries
  task automatic test_random_traffic(int target);
    int stop_at;
    int next_tune;
    int pick;
    int len;
    stop_at   = beats_sent + target;
    next_tune = beats_sent;
    while (beats_sent < stop_at) begin
      if (beats_sent >= next_tune) begin
        req_idle_pct   = pick_pct();
        score_idle_pct = pick_pct();
        next_tune      = beats_sent + $urandom_range(80, 250);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        sym_base = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 8);
          7, 8:                len = $urandom_range(9, QLEN_MAX);
          default:             len = $urandom_range(QLEN_MAX + 1, QLEN_MAX + 8);
        endcase
        send_query(len, $urandom_range(0, 9) != 0);
      end else if (pick < 18) begin
        // word abandoned by a query beat
        send_word($urandom_range(1, 6), 1'b0);
        send_beat(ede_pkg::REQ_QUERY, pick_char(), 1'($urandom_range(0, 1)));
      end else if (pick < 22) begin
        send_word($urandom_range(WLEN_MAX - 4, WLEN_MAX + 6), 1'b1);
      end else begin
        send_word($urandom_range(1, 12), 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result checker: random stall before each result beat, then compare
  // --------------------------------------------------------------------------
  task automatic report_field(string field, int exp_v, int got_v);
    error_count++;
    if (error_count <= 30)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
  endtask

  initial begin
    int     stall;
    score_t exp_s;
    score_bus.ready = 1'b0;
    forever begin
      stall = draw_wait(score_idle_pct);
      @(negedge clk);
      if (stall != 0) begin
        score_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      score_bus.ready <= 1'b1;
      do @(posedge clk); while (score_bus.valid !== 1'b1);
      if (pending_scores.size() == 0) begin
        error_count++;
        if (error_count <= 30)
          $display("%0t: unexpected result beat, expected none, got distance %0d",
                   $time, score_bus.distance);
      end else begin
        exp_s = pending_scores.pop_front();
        words_scored++;
        if (exp_s.word_too_long) wovf_seen++;
        if (exp_s.query_truncated) qovf_seen++;
        if (score_bus.distance !== exp_s.distance)
          report_field("distance", exp_s.distance, score_bus.distance);
        if (score_bus.word_too_long !== exp_s.word_too_long)
          report_field("word_too_long", exp_s.word_too_long, score_bus.word_too_long);
        if (score_bus.query_truncated !== exp_s.query_truncated)
          report_field("query_truncated", exp_s.query_truncated,
                       score_bus.query_truncated);
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = ede_pkg::REQ_QUERY;
    req_bus.char_value = 8'h00;
    req_bus.last       = 1'b0;
    beats_sent         = 0;
    words_scored       = 0;
    wovf_seen          = 0;
    qovf_seen          = 0;
    error_count        = 0;
    req_idle_pct       = 30;
    score_idle_pct     = 30;
    sym_base           = 8'h61;

    // model reset: empty closed query, fresh word
    qry_len    = '0;
    qry_ovf    = 1'b0;
    qry_closed = 1'b1;
    word_restart();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_no_query();
    test_basic_match();
    test_partial_query();
    test_query_overflow();
    test_word_overflow();
    test_random_traffic(1020);

    @(negedge clk);
    req_bus.valid <= 1'b0;

    // drain, then leave room for any stray result beat
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT + 40) @(posedge clk);

    $display("run covered %0d request beats and %0d scored words", beats_sent,
             words_scored);
    $display("words past the word limit: %0d, scored against a clipped query: %0d",
             wovf_seen, qovf_seen);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("timeout with %0d results outstanding", pending_scores.size());
    $display("FAILURE");
    $finish;
  end

endmodule
